// ----- design/pcfp_pkg.sv -----
// package for the programmer command frame parser
// holds payload structs, parse phase codes and buffer geometry; no dependencies
package pcfp_pkg;

  // data buffer geometry
  localparam int unsigned BufferDepth = 256;
  localparam int unsigned IdxW        = $clog2(BufferDepth);

  // framing bytes
  localparam logic [7:0] FlagsMarker = 8'hFF;
  localparam logic [3:0] DumpNibble  = 4'hF;

  // function codes of an input transfer
  localparam logic FuncByte    = 1'b0;
  localparam logic FuncRelease = 1'b1;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhAddr1 = 3'd1,
    PhAddr2 = 3'd2,
    PhAddr3 = 3'd3,
    PhCount = 3'd4,
    PhData  = 3'd5,
    PhDone  = 3'd6,
    PhFlags = 3'd7
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } pcfp_in_t;

  typedef struct packed {
    logic        data_write;
    logic [7:0]  buffer_index;
    logic [7:0]  buffer_byte;
    logic        clear_marks;
    logic        job_start;
    logic        job_ready;
    logic [31:0] start_address;
    logic [8:0]  byte_count;
    logic        dump_mode;
    logic [7:0]  mode_flags;
    logic        led_on;
  } pcfp_out_t;

endpackage

// ----- design/pcfp_in_reg.sv -----
// input register of the frame parser
// holds one accepted host transfer until the parser core consumes it; uses pcfp_pkg
module pcfp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcfp_pkg::pcfp_in_t in_data_i,
  input  logic              consume_i,
  output logic              item_valid_o,
  output pcfp_pkg::pcfp_in_t item_o
);
  import pcfp_pkg::*;

  logic     valid_q, valid_d;
  pcfp_in_t data_q;
  logic     load;

  // free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ----- design/pcfp_core.sv -----
// parser core: phase machine, job registers and result formation
// updates state once per consumed transfer; uses pcfp_pkg
module pcfp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pcfp_pkg::pcfp_in_t item_i,
  output pcfp_pkg::pcfp_out_t result_o
);
  import pcfp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [31:0]      addr_q, addr_d;
  logic [8:0]       count_q, count_d;
  logic [7:0]       flags_q, flags_d;
  logic [IdxW-1:0]  fill_q, fill_d;
  logic [8:0]       left_q, left_d;
  logic             ready_q, ready_d;
  logic             led_q, led_d;

  logic             dump_now;
  logic [8:0]       left_dec;
  logic             wr, clr, start;
  logic [7:0]       widx, wbyte;

  assign dump_now = (flags_q[7:4] == DumpNibble);
  assign left_dec = left_q - 9'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    addr_d  = addr_q;
    count_d = count_q;
    flags_d = flags_q;
    fill_d  = fill_q;
    left_d  = left_q;
    ready_d = ready_q;
    led_d   = led_q;
    wr      = 1'b0;
    clr     = 1'b0;
    start   = 1'b0;
    widx    = 8'd0;
    wbyte   = 8'd0;
    if (item_i.func == FuncRelease) begin
      phase_d = PhIdle;
      ready_d = 1'b0;
    end else begin
      case (phase_q)
        PhIdle: begin
          if (item_i.rx_byte == FlagsMarker) begin
            phase_d = PhFlags;
          end else begin
            addr_d  = {item_i.rx_byte, 24'd0};
            phase_d = PhAddr1;
          end
        end
        PhAddr1: begin
          addr_d[23:16] = item_i.rx_byte;
          phase_d       = PhAddr2;
        end
        PhAddr2: begin
          addr_d[15:8] = item_i.rx_byte;
          phase_d      = PhAddr3;
        end
        PhAddr3: begin
          addr_d[7:0] = item_i.rx_byte;
          phase_d     = PhCount;
        end
        PhCount: begin
          count_d = {1'b0, item_i.rx_byte} + 9'd1;
          if (dump_now) begin
            phase_d = PhDone;
            ready_d = 1'b1;
            start   = 1'b1;
          end else begin
            phase_d = PhData;
            fill_d  = addr_q[IdxW-1:0];
            left_d  = {1'b0, item_i.rx_byte} + 9'd1;
            clr     = 1'b1;
          end
        end
        PhData: begin
          wr     = 1'b1;
          widx   = 8'(fill_q);
          wbyte  = item_i.rx_byte;
          fill_d = fill_q + IdxW'(1);
          left_d = left_dec;
          if (left_dec == 9'd0) begin
            ready_d = 1'b1;
            start   = 1'b1;
            phase_d = PhDone;
          end
        end
        PhFlags: begin
          flags_d = item_i.rx_byte;
          led_d   = (item_i.rx_byte[7:4] != 4'd0);
          phase_d = PhIdle;
        end
        default: begin
          // done: bytes ignored until release
        end
      endcase
    end
  end

  // result fields reflect the state after this transfer
  always_comb begin
    result_o.data_write    = wr;
    result_o.buffer_index  = widx;
    result_o.buffer_byte   = wbyte;
    result_o.clear_marks   = clr;
    result_o.job_start     = start;
    result_o.job_ready     = ready_d;
    result_o.start_address = addr_d;
    result_o.byte_count    = count_d;
    result_o.dump_mode     = (flags_d[7:4] == DumpNibble);
    result_o.mode_flags    = flags_d;
    result_o.led_on        = led_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      addr_q  <= 32'd0;
      count_q <= 9'd0;
      flags_q <= 8'd0;
      fill_q  <= '0;
      left_q  <= 9'd0;
      ready_q <= 1'b0;
      led_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      count_q <= count_d;
      flags_q <= flags_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      ready_q <= ready_d;
      led_q   <= led_d;
    end
  end

  // checks
  a_start_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.job_start |-> result_o.job_ready)
    else $error("job start without job ready");

  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.func == FuncRelease) |=> (phase_q == PhIdle) && !ready_q)
    else $error("release did not return to idle");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.func == FuncByte) && (phase_q == PhData) && (left_q == 9'd1)
    |=> (phase_q == PhDone) && ready_q)
    else $error("last data byte did not complete the job");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (left_q != 9'd0))
    else $error("data phase with no bytes left");

endmodule

// ----- design/pcfp_out_reg.sv -----
// result register of the frame parser
// holds one result until the consumer takes it; uses pcfp_pkg
module pcfp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pcfp_pkg::pcfp_out_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcfp_pkg::pcfp_out_t out_data_o
);
  import pcfp_pkg::*;

  logic      valid_q, valid_d;
  pcfp_out_t data_q;

  // can take a new result when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- design/programmer_command_frame_parser_unit.sv -----
// Programmer command frame parser. Takes one host byte (or a release) per transfer and
// returns exactly one result per transfer. A new transfer can be taken every clock while
// the result side is not stalled; an accepted transfer passes the input register and then
// the result register, with the phase update done between them. Input ready drops only
// while both registers are full and the result side is stalled.
// top level: ties input register, parser core and result register; uses pcfp_pkg
module programmer_command_frame_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcfp_pkg::pcfp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcfp_pkg::pcfp_out_t out_data_o
);
  import pcfp_pkg::*;

  logic      item_valid;
  pcfp_in_t  item;
  logic      out_free;
  logic      step;
  pcfp_out_t result;

  // an item moves on when the result register has room
  assign step = item_valid && out_free;

  pcfp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .consume_i   (step),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  pcfp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item),
    .result_o(result)
  );

  pcfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .result_i   (result),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
